// ----- rtl/hcbd_pkg.sv -----
`default_nettype none

package hcbd_pkg;

  // Decoder phase within one chunked body
  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_SIZE_LF = 3'd1,
    PH_DATA    = 3'd2,
    PH_DATA_CR = 3'd3,
    PH_DATA_LF = 3'd4,
    PH_IDLE    = 3'd5
  } phase_e;

  // Result kinds carried on the master-side tuser
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_EMPTY_LINE = 3'd0,
    ERR_LINE_LONG  = 3'd1,
    ERR_BAD_HEX    = 3'd2,
    ERR_OVER_LIMIT = 3'd3,
    ERR_NO_CRLF    = 3'd4,
    ERR_EARLY_END  = 3'd5
  } err_e;

  // Register indexes (word index taken from paddr[2])
  localparam logic REG_MAX_BODY = 1'b0;

  localparam int unsigned CFG_LEN_W     = 24;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned OUT_TDATA_W   = 40;
  localparam logic [CFG_LEN_W-1:0] MAX_BODY_RESET = 24'd8388608;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef struct packed {
    kind_e                kind;
    logic [BYTE_W-1:0]    data;
    logic [CFG_LEN_W-1:0] len;
    err_e                 code;
  } result_t;

  // Hex digit decode: {valid, nibble}
  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/http_chunked_body_decoder.sv -----
`default_nettype none

// Chunked-framing body decoder. Raw body bytes arrive on the slave stream one per
// transfer (tlast marks a connection close, tdata is then ignored); the decoder strips
// the hex size lines and CRLFs and gives one result per payload byte, one at body
// completion (with the total length) and one on any framing error, on the master
// stream. A byte is taken every clock cycle unless the master stream stalls: each
// transfer lands in an input register, a single pass of logic updates the parse state
// and fills the result register, and the result register lets the next byte enter
// while a finished result waits. Payload leaves before the chunk's trailing CRLF is
// checked, so a later error flags the whole body. After completion or an error the
// decoder idles; a close is then dropped and the next byte starts a fresh body.
// The limit register sits at byte address 0 of the APB port.
module http_chunked_body_decoder #(
  parameter int unsigned SIZE_LINE_LIMIT = 32,  // 2..64 bytes on a size line
  parameter int unsigned LENGTH_BITS     = 24   // 8..32 bits of length counting
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire logic        s_axis_tlast,   // stream_end
  // master stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [hcbd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
                                           // [7:0] out_byte, [31:8] body_length,
                                           // [34:32] error_code, [39:35] zero
  output logic [1:0]       m_axis_tuser,   // [1:0] result_kind
  // APB configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned CNT_W = $clog2(SIZE_LINE_LIMIT);
  localparam int unsigned LB    = LENGTH_BITS;
  localparam int unsigned CW    = (LENGTH_BITS > hcbd_pkg::CFG_LEN_W) ?
                                  LENGTH_BITS : hcbd_pkg::CFG_LEN_W;
  localparam logic [LB-1:0]    LEN_MASK = {LB{1'b1}};
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SIZE_LINE_LIMIT - 1);

  // Configuration register
  logic [hcbd_pkg::CFG_LEN_W-1:0] max_body;

  hcbd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .max_body_o (max_body)
  );

  // Input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       in_end_q;
  logic       out_vld_q, out_vld_d;
  hcbd_pkg::result_t res_q, res_d;
  logic       out_free;
  logic       fire;     // input register advances through the parse step
  logic       in_take;

  assign out_free      = ~out_vld_q | m_axis_tready;
  assign fire          = in_vld_q & out_free;
  assign s_axis_tready = ~in_vld_q | out_free;
  assign in_take       = s_axis_tvalid & s_axis_tready;
  assign in_vld_d      = in_take | (in_vld_q & ~fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
      in_end_q  <= s_axis_tlast;
    end
  end

  // Parse state
  hcbd_pkg::phase_e phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [LB-1:0]    acc_q, acc_d;
  logic             ovf_q, ovf_d;
  logic [LB-1:0]    rem_q, rem_d;
  logic [LB-1:0]    body_q, body_d;
  logic             final_q, final_d;

  // An idle decoder restarts a new body on any byte other than a close: view state as cleared
  logic             restart;
  hcbd_pkg::phase_e eff_phase;
  logic [CNT_W-1:0] eff_cnt;
  logic [LB-1:0]    eff_acc;
  logic             eff_ovf;
  logic [LB-1:0]    eff_rem;
  logic [LB-1:0]    eff_body;
  logic             eff_final;

  assign restart   = (phase_q == hcbd_pkg::PH_IDLE) & ~in_end_q;
  assign eff_phase = restart ? hcbd_pkg::PH_SIZE : phase_q;
  assign eff_cnt   = restart ? '0 : cnt_q;
  assign eff_acc   = restart ? '0 : acc_q;
  assign eff_ovf   = restart ? 1'b0 : ovf_q;
  assign eff_rem   = restart ? '0 : rem_q;
  assign eff_body  = restart ? '0 : body_q;
  assign eff_final = restart ? 1'b0 : final_q;

  // Byte classification and size arithmetic
  logic          is_cr, is_lf, hex_ok, cnt_full;
  logic [4:0]    hex;
  logic [LB+3:0] acc_shift;
  logic          acc_wrap;
  logic [CW-1:0] max_ext, limit_w;
  logic [LB-1:0] limit;
  logic          over_limit;
  logic [CW-1:0] body_ext;

  assign is_cr     = (in_byte_q == hcbd_pkg::CHAR_CR);
  assign is_lf     = (in_byte_q == hcbd_pkg::CHAR_LF);
  assign hex       = hcbd_pkg::hex_nibble(in_byte_q);
  assign hex_ok    = hex[4];
  assign cnt_full  = (eff_cnt >= CNT_FULL);
  assign acc_shift = {eff_acc, hex[3:0]};
  assign acc_wrap  = |acc_shift[LB+3:LB];

  // Effective limit: smaller of the register and the counter range
  assign max_ext    = CW'(max_body);
  assign limit_w    = (max_ext < CW'(LEN_MASK)) ? max_ext : CW'(LEN_MASK);
  assign limit      = limit_w[LB-1:0];
  assign over_limit = eff_ovf | (eff_body > limit) | (eff_acc > (limit - eff_body));
  assign body_ext   = CW'(eff_body);

  // Result of this step
  logic res_has;

  always_comb begin
    res_has   = 1'b0;
    res_d     = res_q;
    res_d.kind = hcbd_pkg::KIND_ERROR;
    res_d.data = '0;
    res_d.len  = '0;
    res_d.code = hcbd_pkg::ERR_EMPTY_LINE;
    if (in_end_q) begin
      res_has    = (phase_q != hcbd_pkg::PH_IDLE);
      res_d.code = hcbd_pkg::ERR_EARLY_END;
    end else begin
      case (eff_phase)
        hcbd_pkg::PH_SIZE: begin
          if (!is_cr) begin
            if (cnt_full) begin
              res_has    = 1'b1;
              res_d.code = hcbd_pkg::ERR_LINE_LONG;
            end else if (!hex_ok) begin
              res_has    = 1'b1;
              res_d.code = hcbd_pkg::ERR_BAD_HEX;
            end
          end
        end
        hcbd_pkg::PH_SIZE_LF: begin
          if (!is_lf) begin
            res_has    = 1'b1;
            res_d.code = hcbd_pkg::ERR_BAD_HEX;
          end else if (eff_cnt == '0) begin
            res_has    = 1'b1;
            res_d.code = hcbd_pkg::ERR_EMPTY_LINE;
          end else if (over_limit) begin
            res_has    = 1'b1;
            res_d.code = hcbd_pkg::ERR_OVER_LIMIT;
          end
        end
        hcbd_pkg::PH_DATA: begin
          res_has    = 1'b1;
          res_d.kind = hcbd_pkg::KIND_PAYLOAD;
          res_d.data = in_byte_q;
        end
        hcbd_pkg::PH_DATA_CR: begin
          if (!is_cr) begin
            res_has    = 1'b1;
            res_d.code = hcbd_pkg::ERR_NO_CRLF;
          end
        end
        hcbd_pkg::PH_DATA_LF: begin
          if (!is_lf) begin
            res_has    = 1'b1;
            res_d.code = hcbd_pkg::ERR_NO_CRLF;
          end else if (eff_final) begin
            res_has    = 1'b1;
            res_d.kind = hcbd_pkg::KIND_DONE;
            res_d.len  = body_ext[hcbd_pkg::CFG_LEN_W-1:0];
          end
        end
        default: begin
          res_has = 1'b0;
        end
      endcase
    end
  end

  // Next parse state
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    rem_d   = rem_q;
    body_d  = body_q;
    final_d = final_q;
    if (fire) begin
      if (in_end_q) begin
        phase_d = hcbd_pkg::PH_IDLE;
      end else if (res_has && (res_d.kind != hcbd_pkg::KIND_PAYLOAD)) begin
        // error or completion: stop until the next body
        phase_d = hcbd_pkg::PH_IDLE;
      end else begin
        phase_d = eff_phase;
        cnt_d   = eff_cnt;
        acc_d   = eff_acc;
        ovf_d   = eff_ovf;
        rem_d   = eff_rem;
        body_d  = eff_body;
        final_d = eff_final;
        case (eff_phase)
          hcbd_pkg::PH_SIZE: begin
            if (is_cr) begin
              phase_d = hcbd_pkg::PH_SIZE_LF;
            end else begin
              cnt_d = eff_cnt + CNT_W'(1);
              if (acc_wrap) begin
                ovf_d = 1'b1;
                acc_d = LEN_MASK;
              end else begin
                acc_d = acc_shift[LB-1:0];
              end
            end
          end
          hcbd_pkg::PH_SIZE_LF: begin
            rem_d = eff_acc;
            if (eff_acc == '0) begin
              final_d = 1'b1;
              phase_d = hcbd_pkg::PH_DATA_CR;
            end else begin
              phase_d = hcbd_pkg::PH_DATA;
            end
          end
          hcbd_pkg::PH_DATA: begin
            body_d = eff_body + LB'(1);
            rem_d  = eff_rem - LB'(1);
            if (eff_rem == LB'(1)) begin
              phase_d = hcbd_pkg::PH_DATA_CR;
            end
          end
          hcbd_pkg::PH_DATA_CR: begin
            phase_d = hcbd_pkg::PH_DATA_LF;
          end
          hcbd_pkg::PH_DATA_LF: begin
            // next size line
            phase_d = hcbd_pkg::PH_SIZE;
            cnt_d   = '0;
            acc_d   = '0;
            ovf_d   = 1'b0;
          end
          default: begin
            phase_d = hcbd_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hcbd_pkg::PH_SIZE;
      cnt_q   <= '0;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
      rem_q   <= '0;
      body_q  <= '0;
      final_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      rem_q   <= rem_d;
      body_q  <= body_d;
      final_q <= final_d;
    end
  end

  // Result register: load on a step, hold while the sink stalls
  assign out_vld_d = fire ? res_has : (out_vld_q & ~m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_has) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = res_q.kind;
  assign m_axis_tdata  = {5'd0, res_q.code, res_q.len, res_q.data};

endmodule

`default_nettype wire

// ----- rtl/hcbd_cfg.sv -----
`default_nettype none

// APB register file: holds the body length limit.
module hcbd_cfg (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [hcbd_pkg::CFG_LEN_W-1:0] max_body_o
);

  logic [hcbd_pkg::CFG_LEN_W-1:0] max_body_q, max_body_d;
  logic                           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready & (paddr[2] == hcbd_pkg::REG_MAX_BODY);

  always_comb begin
    max_body_d = max_body_q;
    if (wr_en) begin
      max_body_d = pwdata[hcbd_pkg::CFG_LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_body_q <= hcbd_pkg::MAX_BODY_RESET;
    end else begin
      max_body_q <= max_body_d;
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == hcbd_pkg::REG_MAX_BODY) begin
      prdata = 32'(max_body_q);
    end
  end

  assign max_body_o = max_body_q;

endmodule

`default_nettype wire

// ----- rtl/hcbd_checker.sv -----
`default_nettype none

module hcbd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Payload carries only the byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == hcbd_pkg::KIND_PAYLOAD) |->
      (m_axis_tdata[39:8] == 32'd0))
    else $error("payload result with length or code set");

  // Completion carries only the length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == hcbd_pkg::KIND_DONE) |->
      (m_axis_tdata[7:0] == 8'd0) && (m_axis_tdata[39:32] == 8'd0))
    else $error("completion result with byte or code set");

  // Error carries a known code only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == hcbd_pkg::KIND_ERROR) |->
      (m_axis_tdata[31:0] == 32'd0) && (m_axis_tdata[39:35] == 5'd0)
      && (m_axis_tdata[34:32] <= 3'd5))
    else $error("malformed error result");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ----- tb/tb_http_chunked_body_decoder.sv -----
`default_nettype none

module tb_http_chunked_body_decoder;

  localparam int unsigned LINE_LIMIT     = 32;
  localparam logic [23:0] LEN_MASK       = 24'hFFFFFF;
  localparam logic [2:0]  ADDR_MAX_BODY  = {hcbd_pkg::REG_MAX_BODY, 2'b00};
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          WATCHDOG_LIMIT = 2000;

  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;
  localparam logic [7:0] CHAR_LOWER_G = 8'h67;
  localparam logic [7:0] CHAR_UPPER_X = 8'h58;

  // Ways a random body is broken on purpose
  typedef enum int {
    FLAW_NONE,
    FLAW_EMPTY_LINE,
    FLAW_LONG_LINE,
    FLAW_BAD_DIGIT,
    FLAW_CR_NO_LF,
    FLAW_OVERFLOW,
    FLAW_NO_DATA_CRLF,
    FLAW_CUT_SHORT,
    FLAW_NOISE
  } flaw_e;

  typedef struct packed {
    logic [7:0] b;
    logic       close;
  } raw_t;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data  = 8'h00;
  logic        s_last  = 1'b0;
  wire         s_ready;
  wire         m_valid;
  logic        m_ready = 1'b0;
  wire  [39:0] m_data;
  wire  [1:0]  m_user;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = 3'd0;
  logic [31:0] pwdata  = 32'd0;
  wire  [31:0] prdata;
  wire         pready;

  http_chunked_body_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),   // [7:0] in_byte
    .s_axis_tlast  (s_last),   // stream_end
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),   // [7:0] out_byte, [31:8] body_length, [34:32] error_code
    .m_axis_tuser  (m_user),   // [1:0] result_kind
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  raw_t              raw_q[$];       // raw body bytes waiting for the driver
  hcbd_pkg::result_t decoded_q[$];   // decoder results still owed by the block
  int unsigned queued_cnt = 0;
  int unsigned sent_cnt   = 0;
  int unsigned mismatches = 0;
  int unsigned stall_cnt  = 0;
  bit          steady     = 1'b0;  // suppress all idling while set

  // Decoder state as the block should hold it
  hcbd_pkg::phase_e ph;
  int unsigned line_cnt;
  logic [31:0] size_acc;
  bit          size_ovf;
  logic [23:0] remain;
  logic [23:0] body_cnt;
  bit          last_chunk;
  logic [23:0] body_limit;

  function automatic bit take_break();
    return !steady && ($urandom_range(99) < 21);
  endfunction

  task automatic log_mismatch(input string what, input logic [39:0] got,
                              input logic [39:0] want);
    $display("mismatch %s: got %0h, want %0h", what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------------
  function automatic int digit_of(input logic [7:0] b);
    if (b >= CHAR_ZERO && b <= CHAR_NINE) return int'(b - CHAR_ZERO);
    if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_F) return int'(b - CHAR_LOWER_A) + 10;
    if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_F) return int'(b - CHAR_UPPER_A) + 10;
    return -1;
  endfunction

  task automatic start_line();
    ph       = hcbd_pkg::PH_SIZE;
    line_cnt = 0;
    size_acc = '0;
    size_ovf = 1'b0;
  endtask

  task automatic clear_body();
    start_line();
    remain     = '0;
    body_cnt   = '0;
    last_chunk = 1'b0;
  endtask

  task automatic post(input hcbd_pkg::kind_e k, input logic [7:0] b,
                      input logic [23:0] len, input hcbd_pkg::err_e c);
    hcbd_pkg::result_t r;
    r.kind = k;
    r.data = b;
    r.len  = len;
    r.code = c;
    decoded_q.push_back(r);
  endtask

  // Any framing fault ends the body; the decoder then waits for a new one
  task automatic raise(input hcbd_pkg::err_e c);
    ph = hcbd_pkg::PH_IDLE;
    post(hcbd_pkg::KIND_ERROR, 8'h00, 24'd0, c);
  endtask

  task automatic decode_step(input logic [7:0] b, input logic close);
    int d;
    if (close) begin
      // A close is dropped once the body is finished
      if (ph != hcbd_pkg::PH_IDLE) raise(hcbd_pkg::ERR_EARLY_END);
    end else begin
      if (ph == hcbd_pkg::PH_IDLE) clear_body();
      case (ph)
        hcbd_pkg::PH_SIZE: begin
          if (b == hcbd_pkg::CHAR_CR) begin
            ph = hcbd_pkg::PH_SIZE_LF;
          end else if (line_cnt + 1 >= LINE_LIMIT) begin
            raise(hcbd_pkg::ERR_LINE_LONG);
          end else begin
            d = digit_of(b);
            if (d < 0) begin
              raise(hcbd_pkg::ERR_BAD_HEX);
            end else begin
              line_cnt++;
              size_acc = size_acc * 16 + d;
              // Saturate and remember the overflow until the line ends
              if (size_acc > LEN_MASK) begin
                size_ovf = 1'b1;
                size_acc = LEN_MASK;
              end
            end
          end
        end
        hcbd_pkg::PH_SIZE_LF: begin
          if (b != hcbd_pkg::CHAR_LF) begin
            raise(hcbd_pkg::ERR_BAD_HEX);
          end else if (line_cnt == 0) begin
            raise(hcbd_pkg::ERR_EMPTY_LINE);
          end else if (size_ovf || body_cnt > body_limit ||
                       size_acc > body_limit - body_cnt) begin
            raise(hcbd_pkg::ERR_OVER_LIMIT);
          end else begin
            remain = size_acc[23:0];
            if (remain == 0) begin
              last_chunk = 1'b1;
              ph = hcbd_pkg::PH_DATA_CR;
            end else begin
              ph = hcbd_pkg::PH_DATA;
            end
          end
        end
        hcbd_pkg::PH_DATA: begin
          body_cnt++;
          remain--;
          if (remain == 0) ph = hcbd_pkg::PH_DATA_CR;
          post(hcbd_pkg::KIND_PAYLOAD, b, 24'd0, hcbd_pkg::ERR_EMPTY_LINE);
        end
        hcbd_pkg::PH_DATA_CR: begin
          if (b != hcbd_pkg::CHAR_CR) raise(hcbd_pkg::ERR_NO_CRLF);
          else ph = hcbd_pkg::PH_DATA_LF;
        end
        hcbd_pkg::PH_DATA_LF: begin
          if (b != hcbd_pkg::CHAR_LF) begin
            raise(hcbd_pkg::ERR_NO_CRLF);
          end else if (last_chunk) begin
            ph = hcbd_pkg::PH_IDLE;
            post(hcbd_pkg::KIND_DONE, 8'h00, body_cnt, hcbd_pkg::ERR_EMPTY_LINE);
          end else begin
            start_line();
          end
        end
        default: ph = hcbd_pkg::PH_IDLE;
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  task automatic push_raw(input logic [7:0] b, input bit close = 1'b0);
    raw_t it;
    it.b     = b;
    it.close = close;
    raw_q.push_back(it);
    queued_cnt++;
  endtask

  task automatic push_crlf();
    push_raw(hcbd_pkg::CHAR_CR);
    push_raw(hcbd_pkg::CHAR_LF);
  endtask

  function automatic logic [7:0] hex_char(input int n, input bit up);
    if (n < 10) return 8'(CHAR_ZERO + n);
    return 8'((up ? CHAR_UPPER_A : CHAR_LOWER_A) + n - 10);
  endfunction

  function automatic int hex_len(input logic [31:0] v);
    int n;
    n = 1;
    while (n < 8 && (v >> (4 * n)) != 0) n++;
    return n;
  endfunction

  function automatic logic [7:0] pick_other(input logic [7:0] avoid);
    logic [7:0] b;
    do b = 8'($urandom); while (b == avoid);
    return b;
  endfunction

  function automatic logic [7:0] pick_non_hex();
    logic [7:0] b;
    do b = 8'($urandom); while (digit_of(b) >= 0 || b == hcbd_pkg::CHAR_CR);
    return b;
  endfunction

  // Size digits only, with pad leading zeros and the letter case chosen by up
  task automatic push_size(input logic [31:0] v, input int pad, input bit up);
    repeat (pad) push_raw(CHAR_ZERO);
    for (int k = hex_len(v) - 1; k >= 0; k--) begin
      push_raw(hex_char(int'((v >> (4 * k)) & 32'hF), up));
    end
  endtask

  // One body: mostly well formed, sometimes broken at one chunk and cut off there
  task automatic queue_body();
    int    n_chunks;
    int    flaw_at;
    int    sz;
    int    pad;
    flaw_e flaw;
    n_chunks = $urandom_range(0, 3);
    flaw     = ($urandom_range(99) < 30) ? flaw_e'($urandom_range(FLAW_EMPTY_LINE, FLAW_NOISE))
                                          : FLAW_NONE;
    flaw_at  = $urandom_range(0, n_chunks);
    for (int c = 0; c <= n_chunks; c++) begin
      if (c == n_chunks) sz = 0;
      else if ($urandom_range(7) == 0) sz = $urandom_range(13, 40);
      else sz = $urandom_range(1, 12);
      if (flaw != FLAW_NONE && c == flaw_at) begin
        case (flaw)
          FLAW_EMPTY_LINE: push_crlf();
          // The byte that fills the line to the limit is refused
          FLAW_LONG_LINE: push_size(sz, LINE_LIMIT - hex_len(sz), $urandom_range(1));
          FLAW_BAD_DIGIT: begin
            repeat ($urandom_range(0, 2)) push_raw(hex_char($urandom_range(15), 1'b0));
            push_raw(pick_non_hex());
          end
          FLAW_CR_NO_LF: begin
            push_size(sz, 0, 1'b0);
            push_raw(hcbd_pkg::CHAR_CR);
            push_raw(pick_other(hcbd_pkg::CHAR_LF));
          end
          FLAW_OVERFLOW: begin
            push_raw(hex_char(1, 1'b0));
            repeat ($urandom_range(6, 8)) push_raw(hex_char($urandom_range(15), 1'b1));
            push_crlf();
          end
          FLAW_NO_DATA_CRLF: begin
            push_size(sz, 0, 1'b0);
            push_crlf();
            repeat (sz) push_raw(8'($urandom));
            if ($urandom_range(1)) begin
              push_raw(pick_other(hcbd_pkg::CHAR_CR));
            end else begin
              push_raw(hcbd_pkg::CHAR_CR);
              push_raw(pick_other(hcbd_pkg::CHAR_LF));
            end
          end
          FLAW_CUT_SHORT: begin
            case ($urandom_range(3))
              0: ;
              1: push_size(sz, 0, 1'b0);
              2: begin
                push_size(sz, 0, 1'b0);
                push_crlf();
                repeat (sz / 2) push_raw(8'($urandom));
              end
              default: begin
                push_size(sz, 0, 1'b0);
                push_crlf();
                repeat (sz) push_raw(8'($urandom));
                push_raw(hcbd_pkg::CHAR_CR);
              end
            endcase
            push_raw(8'($urandom), 1'b1);
          end
          default: begin
            repeat ($urandom_range(1, 6)) push_raw(8'($urandom), $urandom_range(7) == 0);
          end
        endcase
        return;
      end
      // Now and then fill the size line to one byte below the limit
      pad = ($urandom_range(15) == 0) ? LINE_LIMIT - 1 - hex_len(sz) : $urandom_range(0, 2);
      push_size(sz, pad, $urandom_range(1));
      push_crlf();
      repeat (sz) push_raw(8'($urandom));
      push_crlf();
    end
    if ($urandom_range(7) == 0) push_raw(8'($urandom), 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Register access
  // ---------------------------------------------------------------------------
  task automatic read_limit(input logic [23:0] want);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_MAX_BODY;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[23:0] !== want) begin
      log_mismatch("max_body_bytes readback", 40'(prdata), 40'(want));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_limit(input logic [23:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_MAX_BODY;
    pwdata  <= {8'($urandom), v};   // upper bits are not stored
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    body_limit = v;
    read_limit(v);
  endtask

  // Hold until every byte is taken and every result is back, then let the pipe drain
  task automatic settle();
    while (sent_cnt != queued_cnt || decoded_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present queued bytes, hold each until its transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    raw_t nxt;
    if (rst_ni) begin
      if (s_valid && s_ready) begin
        decode_step(s_data, s_last);
        sent_cnt++;
      end
      if (!s_valid || s_ready) begin
        if (raw_q.size() != 0 && !take_break()) begin
          nxt = raw_q.pop_front();
          s_valid <= 1'b1;
          s_data  <= nxt.b;
          s_last  <= nxt.close;
        end else begin
          s_valid <= 1'b0;
          s_data  <= 8'($urandom);
          s_last  <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result transfer with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    hcbd_pkg::result_t w;
    if (rst_ni) begin
      if (m_valid && m_ready) begin
        if (decoded_q.size() == 0) begin
          log_mismatch("result with nothing expected", m_data, 40'd0);
        end else begin
          w = decoded_q.pop_front();
          if (m_user != w.kind) log_mismatch("result_kind", 40'(m_user), 40'(w.kind));
          if (m_data[7:0] != w.data) log_mismatch("out_byte", 40'(m_data[7:0]), 40'(w.data));
          if (m_data[31:8] != w.len) begin
            log_mismatch("body_length", 40'(m_data[31:8]), 40'(w.len));
          end
          if (m_data[34:32] != w.code) begin
            log_mismatch("error_code", 40'(m_data[34:32]), 40'(w.code));
          end
        end
      end
      m_ready <= !take_break();
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    logic [23:0] limits [5];
    int unsigned goals  [5];
    int unsigned goal;
    bit          paused;
    limits = '{24'd0, LEN_MASK, 24'd5, 24'd40, 24'd300};
    goals  = '{90, 230, 220, 230, 180};
    paused = 1'b0;
    clear_body();
    body_limit = hcbd_pkg::MAX_BODY_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: close before any byte gives an early end
    push_raw(8'h00, 1'b1);
    // Two payload bytes at the extremes, then the last chunk
    push_size(2, 0, 1'b0);
    push_crlf();
    push_raw(8'h00);
    push_raw(8'hFF);
    push_crlf();
    push_size(0, 0, 1'b0);
    push_crlf();
    push_crlf();
    // Empty size line
    push_crlf();
    // Non-hex byte on the size line
    push_raw(CHAR_LOWER_G);
    // CR on the size line not followed by LF
    push_size(1, 0, 1'b0);
    push_raw(hcbd_pkg::CHAR_CR);
    push_raw(CHAR_UPPER_X);
    // Trailer field after the last chunk
    push_size(0, 0, 1'b0);
    push_crlf();
    push_raw(CHAR_UPPER_X);
    // Close while idle is dropped
    push_raw(8'h00, 1'b1);
    settle();
    read_limit(hcbd_pkg::MAX_BODY_RESET);

    for (int p = 0; p < 5; p++) begin
      set_limit(limits[p]);
      steady = (p == 1);
      goal = queued_cnt + goals[p];
      while (queued_cnt < goal) begin
        queue_body();
        // Stall the sender mid-phase until every result is back
        if (p == 3 && !paused && queued_cnt + goals[p] / 2 >= goal) begin
          settle();
          paused = 1'b1;
        end
      end
      if (p == 1) begin
        // Leave 20 decoded bytes open at a chunk boundary; the lower limit of the
        // next phase must then refuse the next size line
        push_raw(8'h00, 1'b1);
        push_size(20, 0, 1'b0);
        push_crlf();
        repeat (20) push_raw(8'($urandom));
        push_crlf();
      end
      settle();
      steady = 1'b0;
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
